/* src/stepper_full_step_sequencer_assert.svh */
// ----------------------------------------------------------------------------
// stepper full-step sequencer assertion macros
// concurrent assertion forms used by the checker file
// ----------------------------------------------------------------------------
`ifndef STEPPER_FULL_STEP_SEQUENCER_ASSERT_SVH
`define STEPPER_FULL_STEP_SEQUENCER_ASSERT_SVH

// checked only out of reset
`define STP_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset too
`define STP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/stp_pkg.sv */
// ----------------------------------------------------------------------------
// stp_pkg
// types, widths and constants of the full-step stepper sequencer
// ----------------------------------------------------------------------------
package stp_pkg;

    localparam int COUNT_WIDTH     = 32;
    localparam int ACC_WIDTH       = 32;
    localparam int ELAPSED_WIDTH   = 16;
    localparam int STEPS_WIDTH     = 32;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int INTERVAL_WIDTH  = 32;
    localparam int COIL_WIDTH      = 4;
    localparam int PHASE_WIDTH     = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STEP_INTERVAL = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_REVERSE       = 1'b1;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    localparam logic [PHASE_WIDTH-1:0] PHASE_FWD  = 2'd1;
    localparam logic [PHASE_WIDTH-1:0] PHASE_BACK = 2'd3;

    localparam logic [COUNT_WIDTH-1:0] COUNT_ENDLESS = '1;
    localparam logic [ACC_WIDTH-1:0]   ACC_MAX       = '1;

    localparam logic [COIL_WIDTH-1:0] COIL_PH0 = 4'b1001;
    localparam logic [COIL_WIDTH-1:0] COIL_PH1 = 4'b0011;
    localparam logic [COIL_WIDTH-1:0] COIL_PH2 = 4'b0110;
    localparam logic [COIL_WIDTH-1:0] COIL_PH3 = 4'b1100;

    typedef struct packed {
        logic                     kind;
        logic [ELAPSED_WIDTH-1:0] elapsed_us;
        logic [STEPS_WIDTH-1:0]   step_count;
    } t_in_item;

    typedef struct packed {
        logic [COIL_WIDTH-1:0]  coils;
        logic                   stepped;
        logic [STEPS_WIDTH-1:0] steps_left;
    } t_out_item;

    typedef struct packed {
        logic [INTERVAL_WIDTH-1:0] step_interval_us;
        logic                      reverse;
    } t_cfg;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] remaining_steps;
        logic [ACC_WIDTH-1:0]   time_accumulator;
        logic [PHASE_WIDTH-1:0] phase;
    } t_state;

    function automatic logic [COIL_WIDTH-1:0] coil_pattern(input logic [PHASE_WIDTH-1:0] ph);
        logic [COIL_WIDTH-1:0] pat;
        case (ph)
            2'd0:    pat = COIL_PH0;
            2'd1:    pat = COIL_PH1;
            2'd2:    pat = COIL_PH2;
            default: pat = COIL_PH3;
        endcase
        return pat;
    endfunction

endpackage

/* src/stepper_full_step_sequencer.sv */
// ----------------------------------------------------------------------------
// stepper_full_step_sequencer
// registered path: input register, then result register
// throughput: one item per cycle when the output is not stalled, set by the
//   combinational accumulate, compare and subtract loop on the motor state
// reset: synchronous active low; clears state, config and both valid flags
// ----------------------------------------------------------------------------
module stepper_full_step_sequencer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  stp_pkg::t_in_item                    i_in_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output stp_pkg::t_out_item                   o_out_item,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [stp_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  logic [stp_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data
);

    stp_pkg::t_cfg      cfg;
    stp_pkg::t_state    r_state;
    stp_pkg::t_state    n_state;
    stp_pkg::t_in_item  r_in;
    logic               r_in_valid;
    stp_pkg::t_out_item r_out;
    stp_pkg::t_out_item n_out;
    logic               r_out_valid;
    logic               advance;
    logic               in_accept;

    stp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    stp_step_logic u_step (
        .i_state      (r_state),
        .i_cfg        (cfg),
        .i_item       (r_in),
        .o_next_state (n_state),
        .o_result     (n_out)
    );

    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (r_in_valid && advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_item;
        end
        if (r_in_valid && advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

/* src/stp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// stp_cfg_regs
// configuration register file: step interval and direction
// ----------------------------------------------------------------------------
module stp_cfg_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [stp_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  logic [stp_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data,
    output stp_pkg::t_cfg                        o_cfg
);

    stp_pkg::t_cfg r_cfg;
    stp_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                stp_pkg::CFG_STEP_INTERVAL: begin
                    n_cfg.step_interval_us = i_cfg_data[stp_pkg::INTERVAL_WIDTH-1:0];
                end
                stp_pkg::CFG_REVERSE: begin
                    n_cfg.reverse = i_cfg_data[0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

/* src/stp_step_logic.sv */
// ----------------------------------------------------------------------------
// stp_step_logic
// per-item update: saturating accumulate, step decision, phase and count
// ----------------------------------------------------------------------------
module stp_step_logic (
    input  stp_pkg::t_state    i_state,
    input  stp_pkg::t_cfg      i_cfg,
    input  stp_pkg::t_in_item  i_item,
    output stp_pkg::t_state    o_next_state,
    output stp_pkg::t_out_item o_result
);

    logic [stp_pkg::ACC_WIDTH:0]   sum;
    logic [stp_pkg::ACC_WIDTH-1:0] acc_sat;
    logic                          running;
    logic                          take_step;
    logic                          stepped;
    stp_pkg::t_state               nxt;

    always_comb begin
        sum = {1'b0, i_state.time_accumulator}
            + (stp_pkg::ACC_WIDTH + 1)'(i_item.elapsed_us);
        acc_sat = sum[stp_pkg::ACC_WIDTH] ? stp_pkg::ACC_MAX : sum[stp_pkg::ACC_WIDTH-1:0];
        running = (i_state.remaining_steps != '0) && (i_cfg.step_interval_us != '0);
        take_step = running && (acc_sat >= i_cfg.step_interval_us);

        nxt     = i_state;
        stepped = 1'b0;
        case (i_item.kind)
            stp_pkg::KIND_LOAD: begin
                nxt.remaining_steps  = i_item.step_count[stp_pkg::COUNT_WIDTH-1:0];
                nxt.time_accumulator = '0;
            end
            default: begin
                nxt.time_accumulator = acc_sat;
                if (take_step) begin
                    nxt.time_accumulator = acc_sat - i_cfg.step_interval_us;
                    nxt.phase = i_state.phase
                              + (i_cfg.reverse ? stp_pkg::PHASE_BACK : stp_pkg::PHASE_FWD);
                    if (i_state.remaining_steps != stp_pkg::COUNT_ENDLESS) begin
                        nxt.remaining_steps = i_state.remaining_steps
                                            - stp_pkg::COUNT_WIDTH'(1);
                    end
                    stepped = 1'b1;
                end
            end
        endcase
    end

    assign o_next_state = nxt;

    always_comb begin
        o_result.coils = (nxt.remaining_steps == '0) ? '0 : stp_pkg::coil_pattern(nxt.phase);
        o_result.stepped    = stepped;
        o_result.steps_left = stp_pkg::STEPS_WIDTH'(nxt.remaining_steps);
    end

endmodule

/* src/stp_checker.sv */
// ----------------------------------------------------------------------------
// stp_checker
// port-level checks of the full-step sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "stepper_full_step_sequencer_assert.svh"

module stp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input stp_pkg::t_out_item o_out_item
);

    logic idle_match;
    logic full_step;
    logic out_held;

    assign idle_match = (o_out_item.steps_left == '0) == (o_out_item.coils == '0);
    assign full_step  = (o_out_item.coils == stp_pkg::COIL_PH0)
                     || (o_out_item.coils == stp_pkg::COIL_PH1)
                     || (o_out_item.coils == stp_pkg::COIL_PH2)
                     || (o_out_item.coils == stp_pkg::COIL_PH3);
    assign out_held   = o_out_valid && i_out_stall;

    `STP_ASSERT_CLK(a_idle_coils, i_clk, i_rst_n, o_out_valid |-> idle_match, "coils vs idle count")

    `STP_ASSERT_CLK(a_coil_pattern, i_clk, i_rst_n, (o_out_valid && (o_out_item.coils != '0)) |-> full_step, "bad coils")

    `STP_ASSERT_CLK(a_out_hold, i_clk, i_rst_n, out_held |=> (o_out_valid && $stable(o_out_item)), "word changed")

    `STP_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (!o_out_valid && !o_in_stall), "reset not clear")

endmodule

bind stepper_full_step_sequencer stp_checker u_stp_checker (.*);

/* tb/sv/tb_stepper_full_step_sequencer.sv */
// ----------------------------------------------------------------------------
// tb_stepper_full_step_sequencer
// drives tick and load words into the full-step sequencer and predicts each
// coil word from a local copy of the motor state; a directed table covers
// the field extremes and corner behavior, then a short stopped-motor run
// accumulates time, then randomized phases with random idling on both sides
// ----------------------------------------------------------------------------
module tb_stepper_full_step_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import stp_pkg::*;

    localparam int LONG_HOLD   = 150;
    localparam int STOP_TICKS  = 20;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_WORDS = 50;
    localparam int SETTLE      = 6;
    localparam int DIR_ROWS    = 26;

    typedef enum logic {ROW_WORD, ROW_REG} t_row_op;

    typedef struct packed {
        t_row_op                    op;
        logic [CFG_INDEX_WIDTH-1:0] reg_idx;
        logic [CFG_DATA_WIDTH-1:0]  reg_data;
        t_in_item                   word;
        logic                       fixed;
        t_out_item                  res;
    } t_dir_row;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_stall;
    t_in_item                   i_in_item   = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    t_out_item                  o_out_item;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  i_cfg_data  = '0;

    logic [INTERVAL_WIDTH-1:0] cfg_interval = '0;
    logic                      cfg_reverse  = 1'b0;
    logic [COUNT_WIDTH-1:0]    m_left       = '0;
    logic [ACC_WIDTH-1:0]      m_acc        = '0;
    logic [PHASE_WIDTH-1:0]    m_phase      = '0;

    t_out_item drive_due [$];
    t_out_item due_word;
    int        err_count     = 0;
    bit        tx_quiet      = 1'b0;
    bit        rx_quiet      = 1'b0;
    bit        long_hold_req = 1'b0;
    int        hold_left     = 0;
    t_dir_row  dir_rows [DIR_ROWS];

    stepper_full_step_sequencer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("tb_stepper_full_step_sequencer failed");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_in_item tick(input logic [ELAPSED_WIDTH-1:0] el);
        return '{KIND_TICK, el, '0};
    endfunction

    function automatic t_in_item load(input logic [STEPS_WIDTH-1:0] cnt);
        return '{KIND_LOAD, '0, cnt};
    endfunction

    function automatic t_out_item next_drive(input t_in_item w);
        t_out_item         r;
        logic [ACC_WIDTH:0] sum;
        r.stepped = 1'b0;
        if (w.kind == KIND_LOAD) begin
            m_left = w.step_count[COUNT_WIDTH-1:0];
            m_acc  = '0;
        end else begin
            sum   = {1'b0, m_acc} + (ACC_WIDTH + 1)'(w.elapsed_us);
            m_acc = sum[ACC_WIDTH] ? ACC_MAX : sum[ACC_WIDTH-1:0];
            if (m_left != '0 && cfg_interval != '0 && m_acc >= cfg_interval) begin
                m_acc   = m_acc - cfg_interval;
                m_phase = m_phase + (cfg_reverse ? PHASE_BACK : PHASE_FWD);
                if (m_left != COUNT_ENDLESS) m_left = m_left - COUNT_WIDTH'(1);
                r.stepped = 1'b1;
            end
        end
        case (m_phase)
            2'd0:    r.coils = COIL_PH0;
            2'd1:    r.coils = COIL_PH1;
            2'd2:    r.coils = COIL_PH2;
            default: r.coils = COIL_PH3;
        endcase
        if (m_left == '0) r.coils = '0;
        r.steps_left = STEPS_WIDTH'(m_left);
        return r;
    endfunction

    task automatic send_word(input t_in_item w, input logic fixed, input t_out_item fixed_res);
        int        g;
        t_out_item pred;
        g = tx_quiet ? 0 : idle_len();
        if (g > 0) begin
            i_in_valid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_item  = w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pred = next_drive(w);
        drive_due.push_back(fixed ? fixed_res : pred);
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_in_valid = 1'b0;
        while (drive_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_STEP_INTERVAL) cfg_interval = val[INTERVAL_WIDTH-1:0];
        else if (idx == CFG_REVERSE) cfg_reverse = val[0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // receiver stall, random holds plus one long hold on request
    always @(negedge i_clk) begin
        if (hold_left == 0) begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end else if (!rx_quiet) begin
                hold_left = idle_len();
            end
        end
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else begin
            i_out_stall = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (drive_due.size() == 0) begin
                $error("unexpected result word: coils %0h stepped %0b steps_left %0h",
                       o_out_item.coils, o_out_item.stepped, o_out_item.steps_left);
                err_count++;
            end else begin
                due_word = drive_due.pop_front();
                if (o_out_item.coils !== due_word.coils) begin
                    $error("coils: expected %0h, got %0h", due_word.coils, o_out_item.coils);
                    err_count++;
                end
                if (o_out_item.stepped !== due_word.stepped) begin
                    $error("stepped: expected %0b, got %0b",
                           due_word.stepped, o_out_item.stepped);
                    err_count++;
                end
                if (o_out_item.steps_left !== due_word.steps_left) begin
                    $error("steps_left: expected %0h, got %0h",
                           due_word.steps_left, o_out_item.steps_left);
                    err_count++;
                end
            end
        end
    end

    initial begin
        t_in_item                  w;
        logic [INTERVAL_WIDTH-1:0] ivl;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        dir_rows = '{
            '{ROW_WORD, CFG_STEP_INTERVAL, 32'd0, tick(16'h0), 1'b1, '0},
            '{ROW_WORD, CFG_STEP_INTERVAL, 32'd0,
              '{KIND_TICK, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1, '0},
            '{ROW_WORD, CFG_STEP_INTERVAL, 32'd0,
              '{KIND_LOAD, 16'hFFFF, 32'h0}, 1'b1, '0},
            '{ROW_REG, CFG_STEP_INTERVAL, 32'd1000, '0, 1'b0, '0},
            '{ROW_WORD, CFG_STEP_INTERVAL, 32'd0, load(32'd3), 1'b1,
              '{COIL_PH0, 1'b0, 32'd3}},
            '{ROW_WORD, CFG_STEP_INTERVAL, 32'd0, tick(16'd999), 1'b1,
              '{COIL_PH0, 1'b0, 32'd3}},
            '{ROW_REG, CFG_STEP_INTERVAL, 32'd500, '0, 1'b0, '0},
            '{ROW_WORD, CFG_STEP_INTERVAL, 32'd0, tick(16'd0), 1'b0, '0},
            '{ROW_WORD, CFG_STEP_INTERVAL, 32'd0, tick(16'd2000), 1'b0, '0},
            '{ROW_WORD, CFG_STEP_INTERVAL, 32'd0, tick(16'd0), 1'b0, '0},
            '{ROW_WORD, CFG_STEP_INTERVAL, 32'd0, tick(16'd0), 1'b0, '0},
            '{ROW_REG, CFG_REVERSE, 32'd1, '0, 1'b0, '0},
            '{ROW_WORD, CFG_STEP_INTERVAL, 32'd0, load(COUNT_ENDLESS), 1'b0, '0},
            '{ROW_WORD, CFG_STEP_INTERVAL, 32'd0, tick(16'hFFFF), 1'b0, '0},
            '{ROW_WORD, CFG_STEP_INTERVAL, 32'd0, tick(16'hFFFF), 1'b0, '0},
            '{ROW_WORD, CFG_STEP_INTERVAL, 32'd0, tick(16'hFFFF), 1'b0, '0},
            '{ROW_WORD, CFG_STEP_INTERVAL, 32'd0, tick(16'hFFFF), 1'b0, '0},
            '{ROW_REG, CFG_STEP_INTERVAL, 32'd1, '0, 1'b0, '0},
            '{ROW_WORD, CFG_STEP_INTERVAL, 32'd0, tick(16'd1), 1'b0, '0},
            '{ROW_WORD, CFG_STEP_INTERVAL, 32'd0, load(32'd1), 1'b0, '0},
            '{ROW_WORD, CFG_STEP_INTERVAL, 32'd0, tick(16'd5), 1'b0, '0},
            '{ROW_REG, CFG_REVERSE, 32'd0, '0, 1'b0, '0},
            '{ROW_REG, CFG_STEP_INTERVAL, 32'd0, '0, 1'b0, '0},
            '{ROW_WORD, CFG_STEP_INTERVAL, 32'd0, load(32'hFFFF_FFFE), 1'b0, '0},
            '{ROW_WORD, CFG_STEP_INTERVAL, 32'd0, tick(16'hFFFF), 1'b0, '0},
            '{ROW_WORD, CFG_STEP_INTERVAL, 32'd0, tick(16'd0), 1'b0, '0}
        };

        foreach (dir_rows[k]) begin
            if (dir_rows[k].op == ROW_REG) begin
                settle();
                write_reg(dir_rows[k].reg_idx, dir_rows[k].reg_data);
            end else begin
                send_word(dir_rows[k].word, dir_rows[k].fixed, dir_rows[k].res);
            end
        end

        // stopped motor, accumulator keeps growing
        settle();
        write_reg(CFG_STEP_INTERVAL, '0);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        send_word(load(32'd5), 1'b0, '0);
        repeat (STOP_TICKS) send_word(tick(16'hFFFF), 1'b0, '0);
        settle();
        write_reg(CFG_STEP_INTERVAL, '1);
        send_word(tick(16'd0), 1'b0, '0);
        send_word(tick(16'hFFFF), 1'b0, '0);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            case (ph % 6)
                0:       ivl = $urandom_range(1, 64);
                1:       ivl = $urandom_range(64, 600);
                2:       ivl = 1;
                3:       ivl = $urandom;
                4:       ivl = '0;
                default: ivl = $urandom_range(100, 400);
            endcase
            write_reg(CFG_STEP_INTERVAL, ivl);
            write_reg(CFG_REVERSE, $urandom_range(0, 1));
            tx_quiet = (ph == 3) || (ph == 7);
            rx_quiet = (ph == 3);
            if (ph == 7) long_hold_req = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                w.elapsed_us = ELAPSED_WIDTH'($urandom_range(0, 65535));
                w.step_count = $urandom;
                if ($urandom_range(0, 99) < 12) begin
                    w.kind = KIND_LOAD;
                    case ($urandom_range(0, 9))
                        0:       w.step_count = '0;
                        1:       w.step_count = COUNT_ENDLESS;
                        2:       w.step_count = $urandom;
                        default: w.step_count = $urandom_range(1, 30);
                    endcase
                end else begin
                    w.kind = KIND_TICK;
                    if ($urandom_range(0, 9) > 1) begin
                        w.elapsed_us = ELAPSED_WIDTH'($urandom_range(0, 400));
                    end
                end
                send_word(w, 1'b0, '0);
            end
        end

        i_in_valid = 1'b0;
        while (drive_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_stepper_full_step_sequencer passed");
        end else begin
            $display("tb_stepper_full_step_sequencer failed");
        end
        $finish;
    end

endmodule
